[src/smc_pkg.sv]
// smc_pkg: shared widths, codes and types for the sensor mood classifier
// no dependencies; imported by every module of the block except smc_history_ram

package smc_pkg;

    localparam int MaxWindow   = 512;
    localparam int SampleWidth = 11;
    localparam int HoldWidth   = 10;
    localparam int WinWidth    = 10;
    localparam int AddrWidth   = $clog2(MaxWindow);
    localparam int FillWidth   = $clog2(MaxWindow + 1);
    localparam int SumWidth    = SampleWidth + $clog2(MaxWindow);
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 11;
    localparam int InDataWidth  = 16;
    localparam int OutDataWidth = 16;

    typedef enum logic [1:0] {
        MOOD_STRESS    = 2'd0,
        MOOD_INBETWEEN = 2'd1,
        MOOD_RELAX     = 2'd2,
        MOOD_IDLE      = 2'd3
    } mood_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_CLASSIFY_ENABLE  = 3'd0,
        REG_WINDOW_LENGTH    = 3'd1,
        REG_RELAX_THRESHOLD  = 3'd2,
        REG_STRESS_THRESHOLD = 3'd3,
        REG_RELAX_HOLD       = 3'd4,
        REG_STRESS_HOLD      = 3'd5,
        REG_IDLE_HOLD        = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic                   classify_enable;
        logic [WinWidth-1:0]    window_length;
        logic [SampleWidth-1:0] relax_threshold;
        logic [SampleWidth-1:0] stress_threshold;
        logic [HoldWidth-1:0]   relax_hold;
        logic [HoldWidth-1:0]   stress_hold;
        logic [HoldWidth-1:0]   idle_hold;
    } smc_cfg_t;

    typedef struct packed {
        mood_t mood;
        logic  changed;
    } smc_class_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [SampleWidth-1:0] quotient;
    } smc_div_stat_t;

endpackage

[src/sensor_mood_classifier.sv]
// sensor_mood_classifier: top level, stream ports, config registers and sequencer
// depends on smc_pkg, smc_history_ram, smc_serial_div and smc_classifier

// One skin-conductance sample (Q4, 0..100) comes in per transfer and one
// result goes out per sample. The smoothed value left by the previous sample
// is classified first (stress, in-between, relax or idle, with saturating hold
// counters and an idle detector), then the new sample enters a moving average
// over the last window_length samples, kept in a 512-entry history memory.
// The average is the running sum divided by the fill count, truncated, worked
// out by a bit-serial divider at one quotient bit per cycle. Between its input
// transfer and the next input being taken, an item passes through accepting
// it and reading the oldest sample, updating the sum and history, the divider
// steps (one per sum bit), seeing the divider finish and loading the output
// register. A result waits in the output register while the next sample is
// already being taken; the block only stalls if that result is still not
// taken when the next one is ready. Configuration should be written through
// cfg_we/cfg_index/cfg_data only while no sample is in flight, which the block
// itself does not enforce; indexes beyond the register list are ignored.

module sensor_mood_classifier
    import smc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [InDataWidth-1:0]  s_tdata,   // [10:0] sample
    // output stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataWidth-1:0] m_tdata,   // [1:0] mood, [2] mood_changed, [13:3] smoothed
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDatWidth-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    smc_cfg_t               cfg_reg;
    logic [SampleWidth-1:0] sample_reg;
    logic [SumWidth-1:0]    sum_reg;
    logic [FillWidth-1:0]   fill_reg;
    logic [AddrWidth-1:0]   wi_reg;
    logic [SampleWidth-1:0] avg_reg;
    logic                   m_tvalid_reg;
    mood_t                  out_mood_reg;
    logic                   out_changed_reg;
    logic [SampleWidth-1:0] out_smoothed_reg;

    logic                   in_xfer;
    logic                   out_free;
    logic                   load_out;
    logic [15:0]            wl_ext;
    logic [15:0]            win_ext;
    logic [FillWidth-1:0]   win;
    logic                   evict;
    logic [SumWidth-1:0]    sum_next;
    logic [FillWidth-1:0]   fill_next;
    logic [AddrWidth-1:0]   wi_next;
    logic [FillWidth:0]     wi_wide;
    logic [FillWidth:0]     fill_wide;
    logic [FillWidth:0]     oldest_wide;
    logic [AddrWidth-1:0]   oldest_addr;
    logic [SampleWidth-1:0] rd_data;
    smc_div_stat_t          div_stat;
    smc_class_t             class_res;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_DONE) && out_free;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.classify_enable  <= 1'b0;
            cfg_reg.window_length    <= WinWidth'(10);
            cfg_reg.relax_threshold  <= SampleWidth'(320);
            cfg_reg.stress_threshold <= SampleWidth'(1280);
            cfg_reg.relax_hold       <= HoldWidth'(10);
            cfg_reg.stress_hold      <= HoldWidth'(10);
            cfg_reg.idle_hold        <= HoldWidth'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLASSIFY_ENABLE:  cfg_reg.classify_enable  <= cfg_data[0];
                REG_WINDOW_LENGTH:    cfg_reg.window_length    <= cfg_data[WinWidth-1:0];
                REG_RELAX_THRESHOLD:  cfg_reg.relax_threshold  <= cfg_data[SampleWidth-1:0];
                REG_STRESS_THRESHOLD: cfg_reg.stress_threshold <= cfg_data[SampleWidth-1:0];
                REG_RELAX_HOLD:       cfg_reg.relax_hold       <= cfg_data[HoldWidth-1:0];
                REG_STRESS_HOLD:      cfg_reg.stress_hold      <= cfg_data[HoldWidth-1:0];
                REG_IDLE_HOLD:        cfg_reg.idle_hold        <= cfg_data[HoldWidth-1:0];
                default:              ;
            endcase
        end
    end

    // effective window, saturated to 1..MaxWindow
    always_comb
    begin
        wl_ext  = 16'(cfg_reg.window_length);
        win_ext = wl_ext;
        if (wl_ext == 16'd0)
        begin
            win_ext = 16'd1;
        end
        else if (wl_ext > 16'(MaxWindow))
        begin
            win_ext = 16'(MaxWindow);
        end
        win = win_ext[FillWidth-1:0];
    end

    // oldest entry sits fill_count places behind the write pointer
    always_comb
    begin
        wi_wide   = (FillWidth+1)'(wi_reg);
        fill_wide = {1'b0, fill_reg};
        if (wi_wide >= fill_wide)
        begin
            oldest_wide = wi_wide - fill_wide;
        end
        else
        begin
            oldest_wide = wi_wide + (FillWidth+1)'(MaxWindow) - fill_wide;
        end
        oldest_addr = oldest_wide[AddrWidth-1:0];
    end

    // running sum and fill count update
    always_comb
    begin
        evict     = fill_reg >= win;
        fill_next = evict ? fill_reg : fill_reg + FillWidth'(1);
        sum_next  = sum_reg - (evict ? SumWidth'(rd_data) : '0) + SumWidth'(sample_reg);
        wi_next   = (wi_reg == AddrWidth'(MaxWindow - 1)) ? '0 : wi_reg + AddrWidth'(1);
    end

    smc_history_ram #(
        .Depth (MaxWindow),
        .Width (SampleWidth)
    ) u_history (
        .clk     (clk),
        .wr_en   (state_reg == S_READ),
        .wr_addr (wi_reg),
        .wr_data (sample_reg),
        .rd_en   (in_xfer),
        .rd_addr (oldest_addr),
        .rd_data (rd_data)
    );

    smc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_READ),
        .dividend (sum_next),
        .divisor  (fill_next),
        .stat     (div_stat)
    );

    // classifies the average left by the previous sample
    smc_classifier u_class (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (state_reg == S_READ),
        .cfg     (cfg_reg),
        .average (avg_reg),
        .result  (class_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_READ;
            S_READ: state_next = S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            fill_reg     <= '0;
            wi_reg       <= '0;
            avg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_READ)
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                wi_reg   <= wi_next;
            end
            if (load_out)
            begin
                avg_reg      <= div_stat.quotient;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= s_tdata[SampleWidth-1:0];
        end
        if (load_out)
        begin
            out_mood_reg     <= class_res.mood;
            out_changed_reg  <= class_res.changed;
            out_smoothed_reg <= div_stat.quotient;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OutDataWidth - SampleWidth - 3)'(0), out_smoothed_reg,
                       out_changed_reg, out_mood_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillWidth'(MaxWindow))
        else $error("fill count beyond window capacity");

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input taken while divider still running");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_READ)
        else $error("accepted sample not followed by history update");
`endif

endmodule

[src/smc_history_ram.sv]
// smc_history_ram: generic single-write, single-read sample store
// registered read data; no dependencies

module smc_history_ram #(
    parameter int Depth = 512,
    parameter int Width = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/smc_serial_div.sv]
// smc_serial_div: bit-serial restoring divider, one quotient bit per cycle
// depends on smc_pkg for widths and the status struct

module smc_serial_div
    import smc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SumWidth-1:0]  dividend,
    input  logic [FillWidth-1:0] divisor,
    output smc_div_stat_t        stat
);

    localparam int CntWidth = $clog2(SumWidth);

    logic [SumWidth-1:0]  q_reg;
    logic [FillWidth-1:0] rem_reg;
    logic [FillWidth-1:0] div_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [FillWidth:0]   trial;
    logic [FillWidth:0]   trial_sub;
    logic                 ge;

    // shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, q_reg[SumWidth-1]};
    assign ge        = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CntWidth'(1);
                if (cnt_reg == CntWidth'(SumWidth - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SumWidth-2:0], ge};
            rem_reg <= ge ? trial_sub[FillWidth-1:0] : trial[FillWidth-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = q_reg[SampleWidth-1:0];

endmodule

[src/smc_classifier.sv]
// smc_classifier: hold counters, idle detector and mood register
// depends on smc_pkg for config and result structs and mood codes

module smc_classifier
    import smc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  smc_cfg_t               cfg,
    input  logic [SampleWidth-1:0] average,
    output smc_class_t             result
);

    localparam logic [15:0] Recip5 = 16'hCCCD;

    // floor(7*hold/5), saturated to the counter range
    function automatic logic [HoldWidth-1:0] hold_cap(input logic [HoldWidth-1:0] hold);
        logic [HoldWidth+2:0]  x7;
        logic [HoldWidth+18:0] prod;
        logic [HoldWidth:0]    q;
        x7   = {hold, 3'b000} - {3'b000, hold};
        prod = x7 * Recip5;
        q    = prod[HoldWidth+18:18];
        if (q > {1'b0, {HoldWidth{1'b1}}})
        begin
            q = {1'b0, {HoldWidth{1'b1}}};
        end
        return q[HoldWidth-1:0];
    endfunction

    function automatic logic [HoldWidth-1:0] hold_step(
        input logic [HoldWidth-1:0] cnt,
        input logic                 up,
        input logic [HoldWidth-1:0] cap
    );
        logic [HoldWidth:0] n;
        if (up)
        begin
            n = {1'b0, cnt} + (HoldWidth+1)'(1);
        end
        else if (cnt == '0)
        begin
            n = '0;
        end
        else
        begin
            n = {1'b0, cnt} - (HoldWidth+1)'(1);
        end
        if (n > {1'b0, cap})
        begin
            n = {1'b0, cap};
        end
        return n[HoldWidth-1:0];
    endfunction

    logic [HoldWidth-1:0]   stress_cap_reg;
    logic [HoldWidth-1:0]   relax_cap_reg;
    logic [HoldWidth-1:0]   stress_cnt_reg;
    logic [HoldWidth-1:0]   relax_cnt_reg;
    logic [HoldWidth-1:0]   idle_cnt_reg;
    logic [SampleWidth-1:0] last_avg_reg;
    mood_t                  mood_reg;
    logic                   changed_reg;

    logic [HoldWidth-1:0]   stress_cnt_next;
    logic [HoldWidth-1:0]   relax_cnt_next;
    logic [HoldWidth-1:0]   idle_cnt_next;
    logic [HoldWidth:0]     idle_inc;
    logic signed [SampleWidth:0] diff;
    logic                   steady;
    mood_t                  mood_next;

    // caps follow the hold registers in the next cycle
    always_ff @(posedge clk)
    begin
        stress_cap_reg <= hold_cap(cfg.stress_hold);
        relax_cap_reg  <= hold_cap(cfg.relax_hold);
    end

    always_comb
    begin
        stress_cnt_next = hold_step(stress_cnt_reg, average <= cfg.stress_threshold,
                                    stress_cap_reg);
        relax_cnt_next  = hold_step(relax_cnt_reg, average >= cfg.relax_threshold,
                                    relax_cap_reg);
        diff     = $signed({1'b0, average}) - $signed({1'b0, last_avg_reg});
        steady   = (diff > -(SampleWidth+1)'(16)) && (diff < (SampleWidth+1)'(16));
        idle_inc = {1'b0, idle_cnt_reg} + (HoldWidth+1)'(1);

        mood_next = MOOD_INBETWEEN;
        if (stress_cnt_next > cfg.stress_hold)
        begin
            mood_next = MOOD_STRESS;
        end
        if (relax_cnt_next > cfg.relax_hold)
        begin
            mood_next = MOOD_RELAX;
        end

        if (!steady)
        begin
            idle_cnt_next = '0;
        end
        else if (idle_inc > {1'b0, cfg.idle_hold})
        begin
            idle_cnt_next = cfg.idle_hold;
            mood_next     = MOOD_IDLE;
        end
        else
        begin
            idle_cnt_next = idle_inc[HoldWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stress_cnt_reg <= '0;
            relax_cnt_reg  <= '0;
            idle_cnt_reg   <= '0;
            last_avg_reg   <= '0;
            mood_reg       <= MOOD_INBETWEEN;
            changed_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (cfg.classify_enable)
            begin
                stress_cnt_reg <= stress_cnt_next;
                relax_cnt_reg  <= relax_cnt_next;
                idle_cnt_reg   <= idle_cnt_next;
                last_avg_reg   <= average;
                mood_reg       <= mood_next;
                changed_reg    <= mood_next != mood_reg;
            end
            else
            begin
                changed_reg <= 1'b0;
            end
        end
    end

    assign result.mood    = mood_reg;
    assign result.changed = changed_reg;

endmodule
